// ===== rtl/core/skt_pkg.sv =====
// Shared types and constants for the sorted keyed table.
// Used by skt_mem, skt_ctrl and sorted_keyed_table.
`default_nettype none

package skt_pkg;

  localparam int CAPACITY_DEF     = 256;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int KEY_BITS         = 32;
  localparam int FIELD_BITS       = 9;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_APPEND   = 3'd0,
    ST_INSERT   = 3'd1,
    ST_REPLACE  = 3'd2,
    ST_DELETE   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } skt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PLACE,
    S_RESP
  } skt_state_t;

  typedef struct packed {
    skt_status_t           status;
    logic [FIELD_BITS-1:0] position;
    logic [FIELD_BITS-1:0] entry_count;
  } skt_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_keyed_table.sv =====
// Sorted keyed table: one request in flight; append, replace of the largest key, append to a
// full table or delete on an empty table give their result without a search. Other requests
// search entries from index 0 (one read per cycle, registered memory read), then shift the
// higher entries one per cycle; a middle insert is the worst case.
// A new request is taken once the sequencer is idle, even while a result waits.
// Reset clears count and largest-key record; table contents stay undefined (no sweep).
`default_nettype none

module sorted_keyed_table import skt_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic                  kind,
  input  wire logic [KEY_BITS-1:0]   line_number,
  input  wire logic [31:0]           payload,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output logic [2:0]                 status,
  output logic [FIELD_BITS-1:0]      position,
  output logic [FIELD_BITS-1:0]      entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;
  logic          result_valid, result_taken;
  skt_result_t   result;

  skt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  skt_ctrl #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .line_number  (line_number),
    .payload      (payload),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .result_valid (result_valid),
    .result       (result),
    .result_taken (result_taken)
  );

  // output register loads when empty or being drained this cycle
  assign result_taken = result_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result_taken) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_taken) begin
      status      <= result.status;
      position    <= result.position;
      entry_count <= result.entry_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/skt_mem.sv =====
// Entry store: simple dual-port synchronous memory, one write and one
// registered read per cycle. Depends on skt_pkg for default sizes.
`default_nettype none

module skt_mem import skt_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = KEY_BITS + PAYLOAD_BITS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/skt_ctrl.sv =====
// Sequencer for the sorted table: linear key search, shift up / shift down
// passes and bookkeeping of count and largest key. Depends on skt_pkg.
`default_nettype none

module skt_ctrl import skt_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = KEY_BITS + PAYLOAD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                kind,
  input  wire logic [KEY_BITS-1:0] line_number,
  input  wire logic [31:0]         payload,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  wire logic [EW-1:0]       rd_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [EW-1:0]            wr_data,
  output logic                     result_valid,
  output skt_result_t              result,
  input  wire logic                result_taken
);

  skt_state_t state, state_next;

  logic [CW-1:0]           count, count_next;
  logic [KEY_BITS-1:0]     last_line, last_line_next;
  logic                    last_valid, last_valid_next;
  logic [CW-1:0]           ip, ip_next;
  logic [CW-1:0]           hp, hp_next;
  logic                    up_issue, up_issue_next;
  logic                    dv, dv_next;
  logic [CW-1:0]           dpos, dpos_next;
  logic [KEY_BITS-1:0]     prev_key, prev_key_next;
  logic                    op_kind, op_kind_next;
  logic [KEY_BITS-1:0]     op_key, op_key_next;
  logic [PAYLOAD_BITS-1:0] op_pay, op_pay_next;
  skt_result_t             result_next;

  logic [KEY_BITS-1:0] cmp_key;
  logic [KEY_BITS-1:0] app_key;
  logic [EW-1:0]       app_ent;
  logic                key_eq, key_lt, full, take, goes_app, scan_end, del_last, do_append;
  logic [CW-1:0]       last_pos, pos_up, pos_dn, count_inc;

  assign cmp_key   = rd_data[EW-1 -: KEY_BITS];
  assign key_eq    = dv && (cmp_key == op_key);
  assign key_lt    = dv && (op_key < cmp_key);
  assign full      = (count == CW'(CAPACITY));
  assign last_pos  = count - CW'(1);
  assign count_inc = count + CW'(1);
  assign pos_up    = dpos + CW'(1);
  assign pos_dn    = dpos - CW'(1);
  assign take      = req_valid && (state == S_IDLE);
  assign app_key   = (state == S_IDLE) ? line_number : op_key;
  assign app_ent   = (state == S_IDLE) ? {line_number, payload[PAYLOAD_BITS-1:0]}
                                       : {op_key, op_pay};
  assign goes_app  = (count == '0) || !last_valid || (app_key > last_line);
  assign scan_end  = (ip >= count) && !dv;
  assign del_last  = (dpos == last_pos);

  // key above the largest one or table empty, or search ran off the end
  assign do_append = (take && (kind == KIND_INSERT) && goes_app) ||
                     ((state == S_SCAN) && (op_kind == KIND_INSERT) &&
                      !key_eq && !key_lt && scan_end);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (kind == KIND_DELETE) begin
            state_next = (count == '0) ? S_RESP : S_SCAN;
          end else if (goes_app || (line_number == last_line)) begin
            state_next = S_RESP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (op_kind == KIND_INSERT) begin
          if (key_eq) begin
            state_next = S_RESP;
          end else if (key_lt) begin
            state_next = full ? S_RESP : S_SHIFT_UP;
          end else if (scan_end) begin
            state_next = S_RESP;
          end
        end else begin
          if (key_eq) begin
            state_next = del_last ? S_RESP : S_SHIFT_DN;
          end else if (key_lt || scan_end) begin
            state_next = S_RESP;
          end
        end
      end
      S_SHIFT_UP: begin
        if (dv && (dpos == hp)) begin
          state_next = S_PLACE;
        end
      end
      S_SHIFT_DN: begin
        if (dv && del_last) begin
          state_next = S_RESP;
        end
      end
      S_PLACE: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (result_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    req_stall    = (state != S_IDLE);
    result_valid = (state == S_RESP);
    rd_en        = 1'b0;
    rd_addr      = ip[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = count[AW-1:0];
    wr_data      = app_ent;
    unique case (state)
      S_IDLE: begin
        if (take && (kind == KIND_INSERT) && !goes_app && (line_number == last_line)) begin
          wr_en   = 1'b1;
          wr_addr = last_pos[AW-1:0];
        end
      end
      S_SCAN: begin
        rd_en = (ip < count);
        if ((op_kind == KIND_INSERT) && key_eq) begin
          wr_en   = 1'b1;
          wr_addr = dpos[AW-1:0];
        end
      end
      S_SHIFT_UP: begin
        rd_en = up_issue;
        if (dv) begin
          wr_en   = 1'b1;
          wr_addr = pos_up[AW-1:0];
          wr_data = rd_data;
        end
      end
      S_SHIFT_DN: begin
        rd_en = (ip < count);
        if (dv) begin
          wr_en   = 1'b1;
          wr_addr = pos_dn[AW-1:0];
          wr_data = rd_data;
        end
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = hp[AW-1:0];
      end
      S_RESP: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    if (do_append && !full) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
    end
  end

  // datapath registers
  always_comb begin
    count_next      = count;
    last_line_next  = last_line;
    last_valid_next = last_valid;
    ip_next         = ip;
    hp_next         = hp;
    up_issue_next   = up_issue;
    prev_key_next   = prev_key;
    op_kind_next    = op_kind;
    op_key_next     = op_key;
    op_pay_next     = op_pay;
    result_next     = result;
    // read data from a request that is leaving its state is dropped
    dv_next         = rd_en && (state_next == state);
    dpos_next       = ip;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          op_kind_next = kind;
          op_key_next  = line_number;
          op_pay_next  = payload[PAYLOAD_BITS-1:0];
          ip_next      = '0;
          if (kind == KIND_DELETE) begin
            result_next.status      = ST_NOTFOUND;
            result_next.position    = '0;
            result_next.entry_count = '0;
          end else if (!goes_app) begin
            result_next.status      = ST_REPLACE;
            result_next.position    = FIELD_BITS'(last_pos);
            result_next.entry_count = FIELD_BITS'(count);
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          ip_next = ip + CW'(1);
        end
        if (dv) begin
          prev_key_next = cmp_key;
        end
        if (op_kind == KIND_INSERT) begin
          if (key_eq) begin
            result_next.status      = ST_REPLACE;
            result_next.position    = FIELD_BITS'(dpos);
            result_next.entry_count = FIELD_BITS'(count);
          end else if (key_lt) begin
            if (full) begin
              result_next.status      = ST_FULL;
              result_next.position    = '0;
              result_next.entry_count = FIELD_BITS'(count);
            end else begin
              hp_next       = dpos;
              ip_next       = last_pos;
              up_issue_next = 1'b1;
            end
          end
        end else begin
          if (key_eq) begin
            if (del_last) begin
              count_next              = last_pos;
              result_next.status      = ST_DELETE;
              result_next.position    = FIELD_BITS'(dpos);
              result_next.entry_count = FIELD_BITS'(last_pos);
              // removing the top entry: new largest key is the one below it
              if (last_pos == '0) begin
                last_line_next  = '0;
                last_valid_next = 1'b0;
              end else begin
                last_line_next = prev_key;
              end
            end else begin
              hp_next = dpos;
              ip_next = pos_up;
            end
          end else if (key_lt || scan_end) begin
            result_next.status      = ST_NOTFOUND;
            result_next.position    = '0;
            result_next.entry_count = FIELD_BITS'(count);
          end
        end
      end
      S_SHIFT_UP: begin
        if (up_issue) begin
          ip_next = ip - CW'(1);
          if (ip == hp) begin
            up_issue_next = 1'b0;
          end
        end
      end
      S_SHIFT_DN: begin
        if (rd_en) begin
          ip_next = ip + CW'(1);
        end
        if (dv && del_last) begin
          count_next              = last_pos;
          result_next.status      = ST_DELETE;
          result_next.position    = FIELD_BITS'(hp);
          result_next.entry_count = FIELD_BITS'(last_pos);
        end
      end
      S_PLACE: begin
        count_next              = count_inc;
        result_next.status      = ST_INSERT;
        result_next.position    = FIELD_BITS'(hp);
        result_next.entry_count = FIELD_BITS'(count_inc);
      end
      S_RESP: begin
        dv_next = 1'b0;
      end
      default: begin
        dv_next = 1'b0;
      end
    endcase

    if (do_append) begin
      if (full) begin
        result_next.status      = ST_FULL;
        result_next.position    = '0;
        result_next.entry_count = FIELD_BITS'(count);
      end else begin
        count_next              = count_inc;
        last_line_next          = app_key;
        last_valid_next         = 1'b1;
        result_next.status      = ST_APPEND;
        result_next.position    = FIELD_BITS'(count);
        result_next.entry_count = FIELD_BITS'(count_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      last_line  <= '0;
      last_valid <= 1'b0;
      up_issue   <= 1'b0;
      dv         <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      last_line  <= last_line_next;
      last_valid <= last_valid_next;
      up_issue   <= up_issue_next;
      dv         <= dv_next;
    end
  end

  always_ff @(posedge clk) begin
    ip       <= ip_next;
    hp       <= hp_next;
    dpos     <= dpos_next;
    prev_key <= prev_key_next;
    op_kind  <= op_kind_next;
    op_key   <= op_key_next;
    op_pay   <= op_pay_next;
    result   <= result_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_last_tracks_count: assert property (@(posedge clk) disable iff (rst)
    last_valid == (count != '0))
    else $error("largest-key record out of step with entry count");

  // shift passes read ahead of the write pointer, never the same entry
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("read and write to the same entry in one cycle");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> (result.entry_count == FIELD_BITS'(count)))
    else $error("reported count differs from stored count");

  a_insert_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_UP) |-> (hp < count))
    else $error("insert position beyond table end");

endmodule

`default_nettype wire

// ===== test/sorted_keyed_table_tb.sv =====
// Self-checking testbench for sorted_keyed_table: queued requests, a sorted-table predictor,
// and a monitor that checks every result against it. Needs skt_pkg and the block's RTL.
`timescale 1ns / 100ps

module sorted_keyed_table_tb;
  import skt_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int HOLD_LEN  = 400;
  localparam int TAIL      = 600;
  localparam int LIMIT     = 3000000;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] data;
  } req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  kind = KIND_INSERT;
  logic [KEY_BITS-1:0]   line_number = '0;
  logic [31:0]           payload = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [2:0]            status;
  logic [FIELD_BITS-1:0] position;
  logic [FIELD_BITS-1:0] entry_count;

  req_t        req_q [$];
  skt_result_t result_q [$];
  req_t        nxt_req;
  skt_result_t want;

  // predictor state
  logic [31:0] tbl_key [CAP];
  logic [31:0] tbl_data [CAP];
  int          tbl_count = 0;
  logic [31:0] top_key = '0;
  bit          top_valid = 1'b0;

  int req_idle_pct = 34;
  int rsp_idle_pct = 83;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;

  sorted_keyed_table dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .line_number (line_number),
    .payload     (payload),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  always #10 clk = ~clk;

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic skt_result_t table_apply(input logic op, input logic [31:0] key,
                                              input logic [31:0] data);
    skt_result_t r;
    int          idx;
    int          j;
    bit          add;
    r.status   = ST_NOTFOUND;
    r.position = '0;
    add        = 1'b0;
    if (op == KIND_INSERT) begin
      if (!top_valid || tbl_count == 0 || key > top_key) begin
        add = 1'b1;
      end else if (key == top_key) begin
        idx = tbl_count - 1;
        tbl_data[idx] = data;
        r.status   = ST_REPLACE;
        r.position = 9'(idx);
      end else begin
        idx = 0;
        while (idx < tbl_count && tbl_key[idx] < key) idx++;
        if (idx == tbl_count) begin
          add = 1'b1;
        end else if (tbl_key[idx] == key) begin
          tbl_data[idx] = data;
          r.status   = ST_REPLACE;
          r.position = 9'(idx);
        end else if (tbl_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (j = tbl_count; j > idx; j--) begin
            tbl_key[j]  = tbl_key[j-1];
            tbl_data[j] = tbl_data[j-1];
          end
          tbl_key[idx]  = key;
          tbl_data[idx] = data;
          tbl_count++;
          r.status   = ST_INSERT;
          r.position = 9'(idx);
        end
      end
      if (add) begin
        if (tbl_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          tbl_key[tbl_count]  = key;
          tbl_data[tbl_count] = data;
          r.status   = ST_APPEND;
          r.position = 9'(tbl_count);
          tbl_count++;
          top_key   = key;
          top_valid = 1'b1;
        end
      end
    end else begin
      idx = 0;
      while (idx < tbl_count && tbl_key[idx] != key) idx++;
      if (idx < tbl_count) begin
        for (j = idx; j < tbl_count - 1; j++) begin
          tbl_key[j]  = tbl_key[j+1];
          tbl_data[j] = tbl_data[j+1];
        end
        tbl_count--;
        r.status   = ST_DELETE;
        r.position = 9'(idx);
      end
      // largest-key record follows the table when its key goes away
      if (top_valid && top_key == key) begin
        if (tbl_count > 0) begin
          top_key = tbl_key[tbl_count-1];
        end else begin
          top_key   = '0;
          top_valid = 1'b0;
        end
      end
    end
    r.entry_count = 9'(tbl_count);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) result_q.push_back(table_apply(kind, line_number, payload));
      if (!req_valid || !req_stall) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
          nxt_req = req_q.pop_front();
          req_valid   <= 1'b1;
          kind        <= nxt_req.op;
          line_number <= nxt_req.key;
          payload     <= nxt_req.data;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_LEN;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
    end
  end

  task automatic check_field(input string name, input int exp_val, input int got);
    if (exp_val != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d position %0d count %0d",
                 $time, status, position, entry_count);
        errors++;
      end else begin
        want = result_q.pop_front();
        check_field("status", want.status, status);
        check_field("position", want.position, position);
        check_field("entry_count", want.entry_count, entry_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, result_q.size());
      $display("[sorted_keyed_table] ERROR");
      $finish;
    end
  end

  task automatic push_req(input logic op, input logic [31:0] key, input logic [31:0] data);
    req_t r;
    r.op   = op;
    r.key  = key;
    r.data = data;
    req_q.push_back(r);
  endtask

  // waits until every queued request went in and every result came back
  task automatic drain();
    do @(negedge clk); while (req_q.size() != 0 || req_valid || result_q.size() != 0);
  endtask

  // random requests over a narrow key window so replaces and delete hits are common
  task automatic churn(input int n, input logic [31:0] base, input int span);
    int          i;
    logic [31:0] key;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) key = $urandom;
      else key = base + $urandom_range(0, span - 1);
      push_req(($urandom_range(0, 99) < 45) ? KIND_DELETE : KIND_INSERT, key, $urandom);
    end
  endtask

  // deletes every stored key in random order
  task automatic clear_table();
    logic [31:0] keys [$];
    logic [31:0] t;
    int          i;
    int          j;
    drain();
    for (i = 0; i < tbl_count; i++) keys.push_back(tbl_key[i]);
    for (i = keys.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = keys[i];
      keys[i] = keys[j];
      keys[j] = t;
    end
    for (i = 0; i < keys.size(); i++) push_req(KIND_DELETE, keys[i], $urandom);
    drain();
  endtask

  // fills the table to capacity with appends and middle inserts, then works it while full
  task automatic fill_and_probe();
    logic [31:0] slot [CAP];
    int          later [$];
    int          i;
    int          j;
    int          t;
    for (i = 0; i < CAP; i++) slot[i] = 32'h1000_0000 + i * 64 + $urandom_range(0, 31);
    for (i = 0; i < CAP; i++) begin
      if (i % 5 == 2) later.push_back(i);
      else push_req(KIND_INSERT, slot[i], $urandom);
    end
    for (i = later.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = later[i];
      later[i] = later[j];
      later[j] = t;
    end
    for (i = 0; i < later.size(); i++) push_req(KIND_INSERT, slot[later[i]], $urandom);
    // table is full here
    push_req(KIND_INSERT, slot[10] + 32, $urandom);
    push_req(KIND_INSERT, 32'hFFFF_FFFF, $urandom);
    push_req(KIND_INSERT, 32'h0, $urandom);
    push_req(KIND_INSERT, slot[0], 32'hFFFF_FFFF);
    push_req(KIND_INSERT, slot[100], $urandom);
    push_req(KIND_INSERT, slot[CAP-1], 32'h0);
    push_req(KIND_DELETE, slot[10] + 32, $urandom);
    push_req(KIND_DELETE, slot[CAP-1], $urandom);
    push_req(KIND_INSERT, slot[CAP-1], $urandom);
    push_req(KIND_DELETE, slot[0], $urandom);
    push_req(KIND_INSERT, slot[0], $urandom);
    push_req(KIND_INSERT, slot[200] + 40, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_req(KIND_DELETE, 32'd100, $urandom);           // empty table
    push_req(KIND_INSERT, 32'd100, 32'h0);
    push_req(KIND_INSERT, 32'd100, 32'hFFFF_FFFF);      // replace of the largest key
    push_req(KIND_INSERT, 32'd50, $urandom);
    push_req(KIND_INSERT, 32'd75, $urandom);
    push_req(KIND_INSERT, 32'd50, 32'hA5A5_A5A5);       // replace below the largest
    push_req(KIND_INSERT, 32'hFFFF_FFFF, 32'h0);
    push_req(KIND_INSERT, 32'h0, 32'hFFFF_FFFF);
    push_req(KIND_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    push_req(KIND_DELETE, 32'd75, $urandom);
    push_req(KIND_DELETE, 32'd12345, 32'hFFFF_FFFF);    // miss
    push_req(KIND_DELETE, 32'hFFFF_FFFF, $urandom);     // largest key goes
    push_req(KIND_INSERT, 32'd200, $urandom);
    push_req(KIND_INSERT, 32'd150, $urandom);
    push_req(KIND_DELETE, 32'h0, $urandom);
    push_req(KIND_DELETE, 32'd200, $urandom);
    push_req(KIND_DELETE, 32'd150, $urandom);
    push_req(KIND_DELETE, 32'd100, $urandom);
    push_req(KIND_DELETE, 32'd50, $urandom);
    push_req(KIND_DELETE, 32'd50, $urandom);
    push_req(KIND_INSERT, 32'h0, $urandom);
    push_req(KIND_INSERT, 32'h0, $urandom);
    push_req(KIND_DELETE, 32'h0, $urandom);
    push_req(KIND_INSERT, 32'd7, $urandom);

    churn(70, 32'h0, 48);
    churn(60, 32'hFFFF_FFC0, 64);
    churn(60, $urandom, 40);
    churn(60, 32'h0, 8);
    drain();

    req_idle_pct = 83;
    rsp_idle_pct = 34;
    churn(70, 32'h8000_0000, 48);
    churn(60, 32'hFFFF_FFC0, 64);
    churn(60, $urandom, 40);
    churn(60, 32'hFFFF_FFF8, 8);
    clear_table();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_asks = hold_asks + 1;
    fill_and_probe();
    clear_table();

    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("[sorted_keyed_table] OK");
    end else begin
      $display("[sorted_keyed_table] ERROR");
    end
    $finish;
  end

endmodule
